@@ design/cslm_pkg.sv @@
// Package: shared widths, register indexes, command codes and types of the loss monitor.
`timescale 1ns / 1ps

package cslm_pkg;

    // Field widths
    localparam int ID_W      = 29;
    localparam int SEQ_W     = 8;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Reset values of the watched identifiers
    localparam logic [ID_W-1:0] ID_A_RESET = 29'h100;
    localparam logic [ID_W-1:0] ID_B_RESET = 29'h101;
    localparam logic [ID_W-1:0] ID_C_RESET = 29'h102;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED_ID_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED_ID_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED_ID_C = 2'd2;

    // Input command codes
    localparam logic CMD_FRAME  = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // Last sequence value after reset (no frame seen yet)
    localparam logic [SEQ_W-1:0] SEQ_RESET = 8'hFF;

    // Per-identifier control from the top level to one tracker
    typedef struct packed {
        logic upd;   // frame for this identifier: update history and counter
        logic clr;   // report: clear the lost counter
    } slot_ctrl_t;

endpackage

@@ design/can_sequence_loss_monitor.sv @@
// Top level of the CAN sequence loss monitor.
`timescale 1ns / 1ps

// Counts frames lost on three watched CAN identifiers from the one-byte sequence
// number each frame carries, and reports and clears the three counters on a
// report command. One item is accepted every clock cycle unless a report is
// held in the input register. An accepted item is held in the input register;
// there the identifier compare, the sequence subtract and the saturating counter
// add run combinationally, so a frame updates the counters at the edge after its
// transfer, and a report result is captured in the output register as the report
// leaves the input register. A report waits in the input register only while the
// previous report result has not been taken; frames keep flowing past a pending
// result. Configuration writes always complete.
module can_sequence_loss_monitor
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cslm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cslm_pkg::ID_W-1:0]       cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [cslm_pkg::ID_W-1:0]       frame_id,
    input  logic [cslm_pkg::SEQ_W-1:0]      seq_number,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cslm_pkg::CNT_W-1:0]      lost_count_a,
    output logic [cslm_pkg::CNT_W-1:0]      lost_count_b,
    output logic [cslm_pkg::CNT_W-1:0]      lost_count_c
);

    logic [cslm_pkg::ID_W-1:0]  id_a_reg;
    logic [cslm_pkg::ID_W-1:0]  id_b_reg;
    logic [cslm_pkg::ID_W-1:0]  id_c_reg;

    logic                       s1_valid_reg;
    logic                       s1_cmd_reg;
    logic [cslm_pkg::ID_W-1:0]  s1_id_reg;
    logic [cslm_pkg::SEQ_W-1:0] s1_seq_reg;
    logic                       s1_adv;
    logic                       in_xfer;

    logic                       out_valid_reg;
    logic [cslm_pkg::CNT_W-1:0] cnt_a_reg;
    logic [cslm_pkg::CNT_W-1:0] cnt_b_reg;
    logic [cslm_pkg::CNT_W-1:0] cnt_c_reg;

    logic                       hit_a;
    logic                       hit_b;
    logic                       hit_c;
    logic                       frame_go;
    logic                       report_go;
    cslm_pkg::slot_ctrl_t       ctrl_a;
    cslm_pkg::slot_ctrl_t       ctrl_b;
    cslm_pkg::slot_ctrl_t       ctrl_c;
    logic [cslm_pkg::CNT_W-1:0] lost_a;
    logic [cslm_pkg::CNT_W-1:0] lost_b;
    logic [cslm_pkg::CNT_W-1:0] lost_c;

    // Configuration registers; writes never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_a_reg <= cslm_pkg::ID_A_RESET;
            id_b_reg <= cslm_pkg::ID_B_RESET;
            id_c_reg <= cslm_pkg::ID_C_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cslm_pkg::CFG_WATCHED_ID_A: id_a_reg <= cfg_data;
                cslm_pkg::CFG_WATCHED_ID_B: id_b_reg <= cfg_data;
                cslm_pkg::CFG_WATCHED_ID_C: id_c_reg <= cfg_data;
                default: ;  // unused index: ignored
            endcase
        end
    end

    // Input register handshake: a report holds only while the result is pending
    assign s1_adv   = s1_valid_reg &&
                      ((s1_cmd_reg == cslm_pkg::CMD_FRAME) || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg <= command;
            s1_id_reg  <= frame_id;
            s1_seq_reg <= seq_number;
        end
    end

    // Identifier match, first watched register wins
    assign frame_go  = s1_adv && (s1_cmd_reg == cslm_pkg::CMD_FRAME);
    assign report_go = s1_adv && (s1_cmd_reg == cslm_pkg::CMD_REPORT);
    assign hit_a     = (s1_id_reg == id_a_reg);
    assign hit_b     = (s1_id_reg == id_b_reg) && !hit_a;
    assign hit_c     = (s1_id_reg == id_c_reg) && !hit_a && !hit_b;

    assign ctrl_a = '{upd: frame_go && hit_a, clr: report_go};
    assign ctrl_b = '{upd: frame_go && hit_b, clr: report_go};
    assign ctrl_c = '{upd: frame_go && hit_c, clr: report_go};

    cslm_slot u_slot_a
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_a),
        .seq        (s1_seq_reg),
        .lost_total (lost_a)
    );

    cslm_slot u_slot_b
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_b),
        .seq        (s1_seq_reg),
        .lost_total (lost_b)
    );

    cslm_slot u_slot_c
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_c),
        .seq        (s1_seq_reg),
        .lost_total (lost_c)
    );

    // Result register: captures the counters as the report clears them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (report_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (report_go)
        begin
            cnt_a_reg <= lost_a;
            cnt_b_reg <= lost_b;
            cnt_c_reg <= lost_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign lost_count_a = cnt_a_reg;
    assign lost_count_b = cnt_b_reg;
    assign lost_count_c = cnt_c_reg;

endmodule

@@ design/cslm_slot.sv @@
// Tracker for one watched identifier: last sequence number and saturating lost counter.
`timescale 1ns / 1ps

module cslm_slot
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cslm_pkg::slot_ctrl_t            ctrl,
    input  logic [cslm_pkg::SEQ_W-1:0]      seq,
    output logic [cslm_pkg::CNT_W-1:0]      lost_total
);

    logic [cslm_pkg::SEQ_W-1:0] last_seq_reg;
    logic [cslm_pkg::SEQ_W-1:0] last_seq_next;
    logic                       seq_valid_reg;
    logic                       seq_valid_next;
    logic [cslm_pkg::CNT_W-1:0] lost_reg;
    logic [cslm_pkg::CNT_W-1:0] lost_next;
    logic [cslm_pkg::SEQ_W-1:0] gap;
    logic [cslm_pkg::CNT_W:0]   sum;

    // Frames missed = (new - last - 1) mod 256; zero for an in-order frame
    assign gap = seq - last_seq_reg - {{(cslm_pkg::SEQ_W-1){1'b0}}, 1'b1};
    assign sum = {1'b0, lost_reg} + {{(cslm_pkg::CNT_W-cslm_pkg::SEQ_W+1){1'b0}}, gap};

    // Next state
    always_comb
    begin
        last_seq_next  = last_seq_reg;
        seq_valid_next = seq_valid_reg;
        lost_next      = lost_reg;
        if (ctrl.clr)
        begin
            lost_next = '0;
        end
        else if (ctrl.upd)
        begin
            last_seq_next  = seq;
            seq_valid_next = 1'b1;
            if (seq_valid_reg)
            begin
                // saturate at all ones
                lost_next = sum[cslm_pkg::CNT_W] ? {cslm_pkg::CNT_W{1'b1}}
                                                 : sum[cslm_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg  <= cslm_pkg::SEQ_RESET;
            seq_valid_reg <= 1'b0;
            lost_reg      <= '0;
        end
        else
        begin
            last_seq_reg  <= last_seq_next;
            seq_valid_reg <= seq_valid_next;
            lost_reg      <= lost_next;
        end
    end

    assign lost_total = lost_reg;

endmodule

@@ design/cslm_checker.sv @@
// Port-level checker for the CAN sequence loss monitor, bound to the top level.
`timescale 1ns / 1ps

module cslm_port_checks
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            command,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [cslm_pkg::CNT_W-1:0]      lost_count_a,
    input  logic [cslm_pkg::CNT_W-1:0]      lost_count_b,
    input  logic [cslm_pkg::CNT_W-1:0]      lost_count_c
);

    // A pending result holds its counters until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lost_count_a)
            && $stable(lost_count_b) && $stable(lost_count_c))
        else $error("result changed while stalled");

    // A new result comes only from an earlier report transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && in_ready && (command == cslm_pkg::CMD_REPORT), 2))
        else $error("result without a report transfer");

    // Input side never stalls while the result side can move
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled with result side free");

    // Configuration writes always complete
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind can_sequence_loss_monitor cslm_port_checks u_cslm_port_checks (.*);

@@ test/cslm_checker.sv @@
// Checker: watches the monitor's channels, predicts each report and compares it by field.
`timescale 1ns / 1ps

module cslm_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [cslm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cslm_pkg::ID_W-1:0]      cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           command,
    input  logic [cslm_pkg::ID_W-1:0]      frame_id,
    input  logic [cslm_pkg::SEQ_W-1:0]     seq_number,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [cslm_pkg::CNT_W-1:0]     lost_count_a,
    input  logic [cslm_pkg::CNT_W-1:0]     lost_count_b,
    input  logic [cslm_pkg::CNT_W-1:0]     lost_count_c,
    output int                             error_count,
    output int                             pending_reports
);

    localparam int ID_W  = cslm_pkg::ID_W;
    localparam int SEQ_W = cslm_pkg::SEQ_W;
    localparam int CNT_W = cslm_pkg::CNT_W;

    typedef struct packed {
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        logic [CNT_W-1:0] c;
    } loss_report_t;

    // Reports predicted but not yet seen on the result channel, oldest first
    loss_report_t expected_reports[$];

    // Shadow of the monitor: watched ids, sequence history, lost counters
    logic [ID_W-1:0]  watch_id [3];
    logic [SEQ_W-1:0] prev_seq [3];
    logic             seq_seen [3];
    logic [CNT_W-1:0] lost     [3];

    function automatic logic [CNT_W-1:0] add_clamped(input logic [CNT_W-1:0] acc,
                                                     input logic [SEQ_W-1:0] amount);
        logic [CNT_W:0] sum;
        sum = {1'b0, acc} + amount;
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    // Frame: first matching watched id (a, then b, then c) takes it
    task automatic count_lost_frames(input logic [ID_W-1:0] id, input logic [SEQ_W-1:0] sq);
        int               slot;
        logic [SEQ_W-1:0] step;
        logic [SEQ_W-1:0] gap;
        slot = -1;
        for (int i = 2; i >= 0; i--)
            if (watch_id[i] == id)
                slot = i;
        if (slot < 0)
            return;
        if (seq_seen[slot])
        begin
            step = sq - prev_seq[slot];
            if (step != 8'd1)
            begin
                gap = step - 8'd1;
                lost[slot] = add_clamped(lost[slot], gap);
            end
        end
        prev_seq[slot] = sq;
        seq_seen[slot] = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        loss_report_t want;
        if (!rst_n)
        begin
            watch_id = '{cslm_pkg::ID_A_RESET, cslm_pkg::ID_B_RESET, cslm_pkg::ID_C_RESET};
            for (int i = 0; i < 3; i++)
            begin
                prev_seq[i] = cslm_pkg::SEQ_RESET;
                seq_seen[i] = 1'b0;
                lost[i]     = '0;
            end
            expected_reports.delete();
            error_count     = 0;
            pending_reports = 0;
        end
        else
        begin
            // Register write; the spare index is ignored
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cslm_pkg::CFG_WATCHED_ID_A: watch_id[0] = cfg_data;
                    cslm_pkg::CFG_WATCHED_ID_B: watch_id[1] = cfg_data;
                    cslm_pkg::CFG_WATCHED_ID_C: watch_id[2] = cfg_data;
                    default: ;
                endcase
            end

            // Result transfer against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report transfer with no report pending: a=%0d b=%0d c=%0d",
                           lost_count_a, lost_count_b, lost_count_c);
                    error_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (lost_count_a !== want.a)
                    begin
                        $error("lost_count_a: expected %0d, got %0d", want.a, lost_count_a);
                        error_count++;
                    end
                    if (lost_count_b !== want.b)
                    begin
                        $error("lost_count_b: expected %0d, got %0d", want.b, lost_count_b);
                        error_count++;
                    end
                    if (lost_count_c !== want.c)
                    begin
                        $error("lost_count_c: expected %0d, got %0d", want.c, lost_count_c);
                        error_count++;
                    end
                end
            end

            // Input transfer: report snapshots and clears, frame updates history
            if (in_valid && in_ready)
            begin
                if (command == cslm_pkg::CMD_REPORT)
                begin
                    want.a = lost[0];
                    want.b = lost[1];
                    want.c = lost[2];
                    expected_reports.push_back(want);
                    for (int i = 0; i < 3; i++)
                        lost[i] = '0;
                end
                else
                    count_lost_frames(frame_id, seq_number);
            end

            pending_reports = expected_reports.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// Testbench top: clock, reset, stimulus and verdict for the CAN sequence loss monitor.
`timescale 1ns / 1ps

module testbench;

    localparam int ID_W      = cslm_pkg::ID_W;
    localparam int SEQ_W     = cslm_pkg::SEQ_W;
    localparam int CNT_W     = cslm_pkg::CNT_W;
    localparam int CFG_IDX_W = cslm_pkg::CFG_IDX_W;

    localparam int CLK_LIMIT       = 400000;
    localparam int RESET_CYCLES    = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 165;
    localparam int NUM_PHASES      = 6;
    localparam int MAX_GAP         = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [ID_W-1:0]      cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic                 command    = cslm_pkg::CMD_FRAME;
    logic [ID_W-1:0]      frame_id   = '0;
    logic [SEQ_W-1:0]     seq_number = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic [CNT_W-1:0]     lost_count_a;
    logic [CNT_W-1:0]     lost_count_b;
    logic [CNT_W-1:0]     lost_count_c;

    int error_count;
    int pending_reports;
    int tx_idle_pct = 12;
    int rx_idle_pct = 59;
    int hold_len    = 0;
    int cycle_count = 0;

    // Stimulus-side copy of the watched ids and the next in-order sequence per slot
    logic [ID_W-1:0]  watch_shadow [3];
    logic [SEQ_W-1:0] stim_seq     [3];

    always #2 clk = ~clk;

    can_sequence_loss_monitor dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .frame_id     (frame_id),
        .seq_number   (seq_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lost_count_a (lost_count_a),
        .lost_count_b (lost_count_b),
        .lost_count_c (lost_count_c)
    );

    cslm_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .frame_id        (frame_id),
        .seq_number      (seq_number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .lost_count_a    (lost_count_a),
        .lost_count_b    (lost_count_b),
        .lost_count_c    (lost_count_c),
        .error_count     (error_count),
        .pending_reports (pending_reports)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CLK_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Stop offering items and let every pending report drain
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_reports != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write, issued only with the monitor idle
    task automatic write_config(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] data);
        logic ready_seen;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        ready_seen = 1'b0;
        while (!ready_seen)
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            cslm_pkg::CFG_WATCHED_ID_A: watch_shadow[0] = data;
            cslm_pkg::CFG_WATCHED_ID_B: watch_shadow[1] = data;
            cslm_pkg::CFG_WATCHED_ID_C: watch_shadow[2] = data;
            default: ;
        endcase
    endtask

    task automatic set_watch_ids(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                                 input logic [ID_W-1:0] c);
        write_config(cslm_pkg::CFG_WATCHED_ID_A, a);
        write_config(cslm_pkg::CFG_WATCHED_ID_B, b);
        write_config(cslm_pkg::CFG_WATCHED_ID_C, c);
        write_config(CFG_SPARE_IDX, ID_W'($urandom));
    endtask

    // One input transfer; called and returns at a rising edge
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [SEQ_W-1:0] sq);
        int   gap;
        logic ready_seen;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        frame_id   <= id;
        seq_number <= sq;
        ready_seen = 1'b0;
        while (!ready_seen)
        begin
            @(negedge clk);
            ready_seen = in_ready;
            @(posedge clk);
        end
    endtask

    // Mostly in-order frames on watched ids, some skips, noise ids and reports
    task automatic send_random_item(input int report_pct);
        logic [ID_W-1:0]  id;
        logic [SEQ_W-1:0] sq;
        int               k;
        int               pick;
        if ($urandom_range(99) < report_pct)
        begin
            send_item(cslm_pkg::CMD_REPORT, ID_W'($urandom), SEQ_W'($urandom));
            return;
        end
        k    = $urandom_range(2);
        pick = $urandom_range(99);
        if (pick < 70)
            sq = stim_seq[k] + 8'd1;
        else if (pick < 90)
            sq = stim_seq[k] + SEQ_W'($urandom_range(6));
        else
            sq = SEQ_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 12)
            id = ID_W'($urandom);
        else if (pick < 20)
            id = watch_shadow[k] ^ (ID_W'(1) << $urandom_range(ID_W - 1));
        else
        begin
            id = watch_shadow[k];
            stim_seq[k] = sq;
        end
        send_item(cslm_pkg::CMD_FRAME, id, sq);
    endtask

    // Directed: first frame, 255 as a real number, wraps, repeats, unwatched ids,
    // report fields ignored, history kept over a report, equal watched ids
    task automatic run_directed();
        send_item(cslm_pkg::CMD_REPORT, '0, '0);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_A_RESET, 8'hFF);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_A_RESET, 8'h00);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_A_RESET, 8'h00);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_A_RESET, 8'h05);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_B_RESET, 8'h0A);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_B_RESET, 8'h09);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_C_RESET, 8'h00);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_C_RESET, 8'hFF);
        send_item(cslm_pkg::CMD_FRAME, {ID_W{1'b1}}, 8'h03);
        send_item(cslm_pkg::CMD_FRAME, '0, 8'h00);
        send_item(cslm_pkg::CMD_REPORT, cslm_pkg::ID_A_RESET, 8'h07);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_A_RESET, 8'h07);
        send_item(cslm_pkg::CMD_REPORT, {ID_W{1'b1}}, 8'hFF);
        send_item(cslm_pkg::CMD_REPORT, '0, '0);
        // a and c equal: a takes the frame
        set_watch_ids('0, {ID_W{1'b1}}, '0);
        send_item(cslm_pkg::CMD_FRAME, '0, 8'h01);
        send_item(cslm_pkg::CMD_FRAME, '0, 8'h03);
        send_item(cslm_pkg::CMD_FRAME, {ID_W{1'b1}}, 8'h00);
        send_item(cslm_pkg::CMD_FRAME, {ID_W{1'b1}}, 8'h80);
        send_item(cslm_pkg::CMD_FRAME, cslm_pkg::ID_A_RESET, 8'h08);
        send_item(cslm_pkg::CMD_REPORT, '0, '0);
    endtask

    initial
    begin
        logic [ID_W-1:0] r1;
        logic [ID_W-1:0] r2;
        watch_shadow = '{cslm_pkg::ID_A_RESET, cslm_pkg::ID_B_RESET, cslm_pkg::ID_C_RESET};
        stim_seq     = '{8'd0, 8'd0, 8'd0};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // sender/receiver idling: 12/59, then 59/12, then none
            case (p / 2)
                0: begin tx_idle_pct = 12; rx_idle_pct = 59; end
                1: begin tx_idle_pct = 59; rx_idle_pct = 12; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            r1 = ID_W'($urandom);
            r2 = ID_W'($urandom);
            case (p)
                0: set_watch_ids(r1, r2, ID_W'($urandom));
                1: set_watch_ids({ID_W{1'b1}}, '0, {ID_W{1'b1}});
                2: set_watch_ids(r1, r1, r1);
                3: set_watch_ids(cslm_pkg::ID_A_RESET, cslm_pkg::ID_B_RESET,
                                 cslm_pkg::ID_C_RESET);
                4: set_watch_ids(r1, r2, r2);
                default: set_watch_ids(r1, r2, ID_W'($urandom));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off with report-heavy traffic fills the block
                if (p == 4 && n == 50)
                begin
                    hold_len = HOLD_OFF_CYCLES;
                    repeat (30) send_random_item(40);
                end
                send_random_item(8);
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
